[sv/tst_pkg.sv]
package tst_pkg;

  // table geometry
  localparam int SLOTS   = 16;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int STEP_W  = IDX_W + 1;
  localparam int MAX_OUT = 16;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  // request codes
  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_WAIT   = 2'd2;
  localparam logic [1:0] FUNC_FIRE   = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_WAIT = 2'd1;
  localparam logic [1:0] KIND_FIRE = 2'd2;

  // wait answer when no slot is in use
  localparam logic signed [31:0] WAIT_NONE = -32'sd1;

  // one slot entry as held in the memory
  typedef struct packed {
    logic [31:0] due;
    logic [31:0] handler;
    logic [31:0] arg;
    logic [31:0] id;
  } slot_rec_t;

  // memory write request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    slot_rec_t        rec;
  } mem_wr_t;

  // free slot search result
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } free_t;

endpackage

[sv/tst_slot_mem.sv]
module tst_slot_mem (
  input  logic                        clk,
  input  tst_pkg::mem_wr_t            wr,
  input  logic                        rd_en,
  input  logic [tst_pkg::IDX_W-1:0]   rd_addr,
  output tst_pkg::slot_rec_t          rd_rec
);

  tst_pkg::slot_rec_t mem [tst_pkg::SLOTS];
  tst_pkg::slot_rec_t rd_rec_r;

  // single write port, single registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.rec;
    end
    if (rd_en) begin
      rd_rec_r <= mem[rd_addr];
    end
  end

  assign rd_rec = rd_rec_r;

endmodule

[sv/tst_free_find.sv]
module tst_free_find (
  input  logic [tst_pkg::SLOTS-1:0] used,
  output tst_pkg::free_t            free
);

  // lowest-index free slot
  always_comb begin
    free.found = 1'b0;
    free.idx   = '0;
    for (int i = tst_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free.found = 1'b1;
        free.idx   = tst_pkg::IDX_W'(i);
      end
    end
  end

endmodule

[sv/timeout_slot_table_core.sv]
// Timeout slot table. Each request carries the current millisecond time. Slot
// contents (due time, handler, argument, id) live in a single-port-read memory
// with a registered read port; the in-use flags are flip-flops cleared by
// reset. An add is accepted and then written in S_ADD, because the free slot is
// found from the in-use flags alone. Remove, wait and fire sweep the memory
// one slot per cycle through its read port, pausing while a fire result waits
// on a full result register. Fire results are emitted in slot order; the last
// one of a request carries out_last. A new request is taken once the sweep is
// over, while the previous result may still wait in the output register.
module timeout_slot_table_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [31:0]        in_now_ms,
  input  logic [31:0]        in_interval_ms,
  input  logic [31:0]        in_callback_handler,
  input  logic [31:0]        in_callback_arg,
  input  logic [31:0]        in_target_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [31:0]        out_timer_id,
  output logic [31:0]        out_fired_handler,
  output logic [31:0]        out_fired_arg,
  output logic signed [31:0] out_wait_ms,
  output logic               out_last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;

  // latched request
  logic [1:0]  func_r;
  logic [31:0] now_r, ival_r, hnd_r, arg_r, tid_r;

  // table state
  logic [tst_pkg::SLOTS-1:0] used_r, used_nxt;
  logic [31:0]               next_id_r, next_id_nxt;

  // sweep state
  logic [tst_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [tst_pkg::IDX_W-1:0]  ev_idx_r;
  logic [tst_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       best_vld_r, best_vld_nxt;
  logic [30:0]                best_r, best_nxt;

  // pending fire result, held until we know whether it is the last
  logic        pend_vld_r, pend_vld_nxt;
  logic [31:0] pend_id_r, pend_hnd_r, pend_arg_r;

  // result register
  logic               out_valid_r;
  logic [1:0]         out_kind_r, out_kind_nxt;
  logic [31:0]        out_id_r, out_id_nxt;
  logic [31:0]        out_hnd_r, out_hnd_nxt;
  logic [31:0]        out_arg_r, out_arg_nxt;
  logic signed [31:0] out_wait_r, out_wait_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_ld;
  logic               out_free;

  tst_pkg::mem_wr_t   wr;
  tst_pkg::slot_rec_t rd_rec;
  tst_pkg::free_t     free;
  logic               rd_en;
  logic [tst_pkg::IDX_W-1:0] rd_addr;

  // evaluation of the slot last read from the memory
  logic        ev_vld, ev_used, is_due, rm_hit, fire_hit, stall, sweep_end;
  logic [31:0] diff;
  logic [30:0] wait_d;

  tst_slot_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_rec  (rd_rec)
  );

  tst_free_find u_free (
    .used (used_r),
    .free (free)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // compare of the slot just read against the request
  always_comb begin
    ev_vld    = (state_r == S_SCAN) && (step_r != '0);
    ev_used   = used_r[ev_idx_r];
    diff      = rd_rec.due - now_r;
    is_due    = diff[31] || (diff == 32'd0);
    wait_d    = diff[31] ? 31'd0 : diff[30:0];
    rm_hit    = ev_vld && (func_r == tst_pkg::FUNC_REMOVE) && ev_used
                && (rd_rec.id == tid_r);
    fire_hit  = ev_vld && (func_r == tst_pkg::FUNC_FIRE) && ev_used && is_due
                && (cnt_r < tst_pkg::CNT_W'(tst_pkg::MAX_OUT));
    stall     = fire_hit && pend_vld_r && !out_free;
    sweep_end = (step_r == tst_pkg::STEP_W'(tst_pkg::SLOTS));
    rd_addr   = step_r[tst_pkg::IDX_W-1:0];
    rd_en     = (state_r == S_SCAN) && !stall && !sweep_end;
  end

  // add writes the new slot
  always_comb begin
    wr.en          = (state_r == S_ADD) && out_free && free.found;
    wr.addr        = free.idx;
    wr.rec.due     = now_r + (ival_r[31] ? 32'd0 : ival_r);
    wr.rec.handler = hnd_r;
    wr.rec.arg     = arg_r;
    wr.rec.id      = next_id_r;
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    next_id_nxt  = next_id_r;
    step_nxt     = step_r;
    cnt_nxt      = cnt_r;
    best_vld_nxt = best_vld_r;
    best_nxt     = best_r;
    pend_vld_nxt = pend_vld_r;
    out_ld       = 1'b0;
    out_kind_nxt = out_kind_r;
    out_id_nxt   = out_id_r;
    out_hnd_nxt  = out_hnd_r;
    out_arg_nxt  = out_arg_r;
    out_wait_nxt = out_wait_r;
    out_last_nxt = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          step_nxt     = '0;
          cnt_nxt      = '0;
          best_vld_nxt = 1'b0;
          pend_vld_nxt = 1'b0;
          state_nxt    = (in_func == tst_pkg::FUNC_ADD) ? S_ADD : S_SCAN;
        end
      end
      S_ADD: begin
        if (out_free) begin
          out_ld       = 1'b1;
          out_kind_nxt = tst_pkg::KIND_ADD;
          out_id_nxt   = free.found ? next_id_r : 32'd0;
          out_hnd_nxt  = '0;
          out_arg_nxt  = '0;
          out_wait_nxt = '0;
          out_last_nxt = 1'b1;
          if (free.found) begin
            used_nxt[free.idx] = 1'b1;
            next_id_nxt        = next_id_r + 32'd1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!stall) begin
          if (rm_hit) begin
            used_nxt[ev_idx_r] = 1'b0;
          end
          if (ev_vld && (func_r == tst_pkg::FUNC_WAIT) && ev_used) begin
            if (!best_vld_r || (wait_d < best_r)) begin
              best_nxt = wait_d;
            end
            best_vld_nxt = 1'b1;
          end
          if (fire_hit) begin
            used_nxt[ev_idx_r] = 1'b0;
            cnt_nxt            = cnt_r + tst_pkg::CNT_W'(1);
            pend_vld_nxt       = 1'b1;
            if (pend_vld_r) begin
              out_ld       = 1'b1;
              out_kind_nxt = tst_pkg::KIND_FIRE;
              out_id_nxt   = pend_id_r;
              out_hnd_nxt  = pend_hnd_r;
              out_arg_nxt  = pend_arg_r;
              out_wait_nxt = '0;
              out_last_nxt = 1'b0;
            end
          end
          if (sweep_end) begin
            state_nxt = S_FIN;
          end else begin
            step_nxt = step_r + tst_pkg::STEP_W'(1);
          end
        end
      end
      S_FIN: begin
        priority if (func_r == tst_pkg::FUNC_WAIT) begin
          if (out_free) begin
            out_ld       = 1'b1;
            out_kind_nxt = tst_pkg::KIND_WAIT;
            out_id_nxt   = '0;
            out_hnd_nxt  = '0;
            out_arg_nxt  = '0;
            out_wait_nxt = best_vld_r ? $signed({1'b0, best_r}) : tst_pkg::WAIT_NONE;
            out_last_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if ((func_r == tst_pkg::FUNC_FIRE) && pend_vld_r) begin
          if (out_free) begin
            out_ld       = 1'b1;
            out_kind_nxt = tst_pkg::KIND_FIRE;
            out_id_nxt   = pend_id_r;
            out_hnd_nxt  = pend_hnd_r;
            out_arg_nxt  = pend_arg_r;
            out_wait_nxt = '0;
            out_last_nxt = 1'b1;
            pend_vld_nxt = 1'b0;
            state_nxt    = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      next_id_r   <= 32'd1;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      next_id_r   <= next_id_nxt;
      pend_vld_r  <= pend_vld_nxt;
      step_r      <= step_nxt;
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r <= in_func;
      now_r  <= in_now_ms;
      ival_r <= in_interval_ms;
      hnd_r  <= in_callback_handler;
      arg_r  <= in_callback_arg;
      tid_r  <= in_target_id;
    end
    if (rd_en) begin
      ev_idx_r <= rd_addr;
    end
    cnt_r      <= cnt_nxt;
    best_vld_r <= best_vld_nxt;
    best_r     <= best_nxt;
    if (fire_hit && !stall) begin
      pend_id_r  <= rd_rec.id;
      pend_hnd_r <= rd_rec.handler;
      pend_arg_r <= rd_rec.arg;
    end
    if (out_ld) begin
      out_kind_r <= out_kind_nxt;
      out_id_r   <= out_id_nxt;
      out_hnd_r  <= out_hnd_nxt;
      out_arg_r  <= out_arg_nxt;
      out_wait_r <= out_wait_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_timer_id      = out_id_r;
  assign out_fired_handler = out_hnd_r;
  assign out_fired_arg     = out_arg_r;
  assign out_wait_ms       = out_wait_r;
  assign out_last          = out_last_r;

  // memory is written only by an add
  a_wr_only_add: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == S_ADD))
    else $error("slot memory written outside add");

  // a held fire result exists only during a fire sweep
  a_pend_fire: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> ((state_r == S_SCAN || state_r == S_FIN)
                    && func_r == tst_pkg::FUNC_FIRE))
    else $error("pending fire result outside fire sweep");

  // sweep counter never passes the table end
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= tst_pkg::STEP_W'(tst_pkg::SLOTS))
    else $error("sweep counter out of range");

  // a successful add claims exactly one more slot
  a_add_claims: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> ($countones(used_r) == $countones($past(used_r)) + 1))
    else $error("add did not claim exactly one slot");

  // no result is overwritten while it waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld |-> out_free)
    else $error("result register loaded while full");

endmodule

[tb/timeout_slot_table_core_tb.sv]
`timescale 1ns / 1ps

module timeout_slot_table_core_tb;

  localparam int RANDOM_REQS    = 400;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4 * (tst_pkg::SLOTS + 2);

  // one request as offered on the input channel
  typedef struct {
    logic [1:0]  func;
    logic [31:0] now_ms;
    logic [31:0] interval_ms;
    logic [31:0] handler;
    logic [31:0] arg;
    logic [31:0] target_id;
  } req_t;

  // one answer as seen on the result channel
  typedef struct {
    logic [1:0]         kind;
    logic [31:0]        timer_id;
    logic [31:0]        handler;
    logic [31:0]        arg;
    logic signed [31:0] wait_ms;
    logic               last;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_func = tst_pkg::FUNC_WAIT;
  logic [31:0]        in_now_ms = '0;
  logic [31:0]        in_interval_ms = '0;
  logic [31:0]        in_callback_handler = '0;
  logic [31:0]        in_callback_arg = '0;
  logic [31:0]        in_target_id = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_kind;
  logic [31:0]        out_timer_id;
  logic [31:0]        out_fired_handler;
  logic [31:0]        out_fired_arg;
  logic signed [31:0] out_wait_ms;
  logic               out_last;

  timeout_slot_table_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_now_ms           (in_now_ms),
    .in_interval_ms      (in_interval_ms),
    .in_callback_handler (in_callback_handler),
    .in_callback_arg     (in_callback_arg),
    .in_target_id        (in_target_id),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_timer_id        (out_timer_id),
    .out_fired_handler   (out_fired_handler),
    .out_fired_arg       (out_fired_arg),
    .out_wait_ms         (out_wait_ms),
    .out_last            (out_last)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  req_t    request_q[$];
  answer_t owed_answers[$];

  // shadow copy of the timer table
  logic        tbl_used[tst_pkg::SLOTS];
  logic [31:0] tbl_due[tst_pkg::SLOTS];
  logic [31:0] tbl_hnd[tst_pkg::SLOTS];
  logic [31:0] tbl_arg[tst_pkg::SLOTS];
  logic [31:0] tbl_id[tst_pkg::SLOTS];
  logic [31:0] tbl_next_id = 32'd1;

  int fault_count   = 0;
  int results_seen  = 0;
  int reqs_sent     = 0;
  int timers_added  = 0;
  int adds_refused  = 0;
  int timers_freed  = 0;
  int timers_fired  = 0;
  int wait_answers  = 0;

  initial begin
    for (int s = 0; s < tst_pkg::SLOTS; s++) tbl_used[s] = 1'b0;
  end

  // apply one request to the shadow table and queue the answers it owes
  task automatic apply_timer_request(input req_t r);
    answer_t            ans;
    answer_t            held;
    logic               have_held;
    logic [31:0]        ival;
    logic signed [31:0] rem;
    logic signed [31:0] best;
    logic               any;
    int                 n;
    int                 i;
    ans = '{kind: tst_pkg::KIND_ADD, timer_id: '0, handler: '0, arg: '0,
            wait_ms: '0, last: 1'b1};
    held = ans;
    have_held = 1'b0;
    n = 0;
    any = 1'b0;
    best = '0;
    case (r.func)
      tst_pkg::FUNC_ADD: begin
        // interval with the top bit set counts as zero
        ival = r.interval_ms[31] ? 32'd0 : r.interval_ms;
        for (i = 0; i < tst_pkg::SLOTS; i++) begin
          if (!tbl_used[i]) begin
            tbl_used[i] = 1'b1;
            tbl_due[i] = r.now_ms + ival;
            tbl_hnd[i] = r.handler;
            tbl_arg[i] = r.arg;
            tbl_id[i] = tbl_next_id;
            ans.timer_id = tbl_next_id;
            tbl_next_id = tbl_next_id + 32'd1;
            timers_added++;
            break;
          end
        end
        if (ans.timer_id == '0) adds_refused++;
        owed_answers.push_back(ans);
      end
      tst_pkg::FUNC_REMOVE: begin
        for (i = 0; i < tst_pkg::SLOTS; i++) begin
          if (tbl_used[i] && tbl_id[i] == r.target_id) begin
            tbl_used[i] = 1'b0;
            timers_freed++;
          end
        end
      end
      tst_pkg::FUNC_WAIT: begin
        // least remaining time, modulo 2^32, floored at zero
        for (i = 0; i < tst_pkg::SLOTS; i++) begin
          if (tbl_used[i]) begin
            rem = tbl_due[i] - r.now_ms;
            if (rem < 0) rem = 0;
            if (!any || rem < best) best = rem;
            any = 1'b1;
          end
        end
        ans.kind = tst_pkg::KIND_WAIT;
        ans.wait_ms = any ? best : tst_pkg::WAIT_NONE;
        wait_answers++;
        owed_answers.push_back(ans);
      end
      default: begin
        // fire every due slot in index order, mark the final one
        for (i = 0; i < tst_pkg::SLOTS && n < tst_pkg::MAX_OUT; i++) begin
          rem = tbl_due[i] - r.now_ms;
          if (tbl_used[i] && rem <= 0) begin
            tbl_used[i] = 1'b0;
            if (have_held) owed_answers.push_back(held);
            held = '{kind: tst_pkg::KIND_FIRE, timer_id: tbl_id[i], handler: tbl_hnd[i],
                     arg: tbl_arg[i], wait_ms: '0, last: 1'b0};
            have_held = 1'b1;
            n++;
            timers_fired++;
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          owed_answers.push_back(held);
        end
      end
    endcase
  endtask

  task automatic push_req(input logic [1:0] func, input logic [31:0] now_ms,
                          input logic [31:0] ival, input logic [31:0] hnd,
                          input logic [31:0] arg, input logic [31:0] tid);
    req_t r;
    r = '{func: func, now_ms: now_ms, interval_ms: ival, handler: hnd,
          arg: arg, target_id: tid};
    request_q.push_back(r);
  endtask

  // sender: bursts of requests separated by random gaps
  req_t offered;
  int   burst_left = 1;
  int   gap_left = 0;

  always @(posedge clk) begin
    logic stuck;
    logic nxt_valid;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        apply_timer_request(offered);
        reqs_sent++;
      end
      stuck = in_valid && !in_ready;
      if (!stuck) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() != 0) begin
          offered = request_q.pop_front();
          nxt_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        in_valid <= nxt_valid;
        in_func <= offered.func;
        in_now_ms <= offered.now_ms;
        in_interval_ms <= offered.interval_ms;
        in_callback_handler <= offered.handler;
        in_callback_arg <= offered.arg;
        in_target_id <= offered.target_id;
      end
    end
  end

  // receiver: checks answers, stalls on a rotating pattern plus two long holds
  logic [15:0] stall_pat = 16'hFFFF;
  int          pat_age = 0;
  int          hold_left = 0;
  int          holds_done = 0;

  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    logic    nxt_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{kind: out_kind, timer_id: out_timer_id, handler: out_fired_handler,
                arg: out_fired_arg, wait_ms: out_wait_ms, last: out_last};
        results_seen++;
        if (owed_answers.size() == 0) begin
          if (fault_count < 10)
            $display("unexpected result: kind %0d id %h handler %h arg %h wait %0d last %0d",
                     got.kind, got.timer_id, got.handler, got.arg, got.wait_ms, got.last);
          fault_count++;
        end else begin
          want = owed_answers.pop_front();
          if (got.kind !== want.kind || got.timer_id !== want.timer_id ||
              got.handler !== want.handler || got.arg !== want.arg ||
              got.wait_ms !== want.wait_ms || got.last !== want.last) begin
            if (fault_count < 10) begin
              $display("mismatch on result %0d (expected / actual):", results_seen);
              $display("  kind %0d / %0d  id %h / %h  last %0d / %0d",
                       want.kind, got.kind, want.timer_id, got.timer_id, want.last, got.last);
              $display("  handler %h / %h  arg %h / %h  wait %0d / %0d",
                       want.handler, got.handler, want.arg, got.arg,
                       want.wait_ms, got.wait_ms);
            end
            fault_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if ((holds_done == 0 && results_seen >= 60) ||
                   (holds_done == 1 && results_seen >= 220)) begin
        // long hold so the table backs up and stalls the sender
        hold_left = LONG_HOLD;
        holds_done++;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
        pat_age++;
        if (pat_age == 64) begin
          pat_age = 0;
          case ($urandom_range(0, 3))
            0: stall_pat = 16'hFFFF;
            1: stall_pat = 16'($urandom);
            2: stall_pat = 16'($urandom | $urandom);
            default: stall_pat = 16'($urandom & $urandom) | 16'h0001;
          endcase
        end
      end
      out_ready <= nxt_ready;
    end
  end

  // watchdog on cycles without any handshake
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no handshake for %0d cycles, %0d answers outstanding",
                   idle_cycles, owed_answers.size());
          $display("timeout_slot_table_core_tb: errors");
          $finish;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [31:0] t_ms;
    logic [31:0] ival;
    logic [31:0] tid;
    logic [31:0] stamp;
    logic [1:0]  func;
    int          adds_gen;
    int          pick;
    int          k;

    // empty table: wait, fire and remove with nothing in use
    push_req(tst_pkg::FUNC_WAIT, 32'd0, '0, '0, '0, '0);
    push_req(tst_pkg::FUNC_FIRE, 32'd0, '0, '0, '0, '0);
    push_req(tst_pkg::FUNC_REMOVE, 32'd0, '0, '0, '0, 32'd5);
    // adds just before the time wraps, with clamped and extreme intervals
    t_ms = 32'hFFFF_FFF0;
    push_req(tst_pkg::FUNC_ADD, t_ms, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, '0);
    push_req(tst_pkg::FUNC_ADD, t_ms, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, '0);
    push_req(tst_pkg::FUNC_ADD, t_ms, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 32'h5A5A_A5A5, '0);
    push_req(tst_pkg::FUNC_ADD, t_ms, 32'h0000_0020, 32'h1234_5678, 32'h8765_4321, '0);
    for (k = 0; k < tst_pkg::SLOTS - 4; k++)
      push_req(tst_pkg::FUNC_ADD, t_ms, 32'd5, $urandom, $urandom, '0);
    // table full: refused with id zero
    push_req(tst_pkg::FUNC_ADD, t_ms, 32'd1, $urandom, $urandom, '0);
    push_req(tst_pkg::FUNC_WAIT, t_ms, '0, '0, '0, '0);
    push_req(tst_pkg::FUNC_REMOVE, t_ms, '0, '0, '0, 32'd3);
    push_req(tst_pkg::FUNC_REMOVE, t_ms, '0, '0, '0, 32'hFFFF_FFFF);
    // after the wrap: all but the far slot are due
    push_req(tst_pkg::FUNC_FIRE, 32'h0000_0010, '0, '0, '0, '0);
    push_req(tst_pkg::FUNC_WAIT, 32'h0000_0010, '0, '0, '0, '0);
    push_req(tst_pkg::FUNC_FIRE, 32'h0000_0010, '0, '0, '0, '0);
    adds_gen = tst_pkg::SLOTS + 1;

    // random traffic on a mostly advancing clock that crosses the wrap
    t_ms = 32'hFFFF_FF00;
    for (k = 0; k < RANDOM_REQS; k++) begin
      if ($urandom_range(0, 49) == 0) t_ms = $urandom;
      else t_ms = t_ms + $urandom_range(0, 8);
      // occasional out-of-order timestamp
      stamp = ($urandom_range(0, 19) == 0) ? $urandom : t_ms;
      pick = $urandom_range(0, 99);
      func = (pick < 40) ? tst_pkg::FUNC_ADD :
             (pick < 55) ? tst_pkg::FUNC_REMOVE :
             (pick < 75) ? tst_pkg::FUNC_WAIT : tst_pkg::FUNC_FIRE;
      case ($urandom_range(0, 9))
        0: ival = $urandom | 32'h8000_0000;
        1: ival = $urandom & 32'h7FFF_FFFF;
        2: ival = 32'h7FFF_FFFF - $urandom_range(0, 15);
        default: ival = $urandom_range(0, 60);
      endcase
      // mostly ids that were handed out recently
      if ($urandom_range(0, 9) < 7)
        tid = $urandom_range(adds_gen + 1, (adds_gen > 40) ? adds_gen - 40 : 0);
      else
        tid = $urandom;
      if (func == tst_pkg::FUNC_ADD) adds_gen++;
      push_req(func, stamp, ival, $urandom, $urandom, tid);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || in_valid) @(posedge clk);
    while (owed_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run: %0d requests, %0d timers added, %0d adds refused, %0d removed",
             reqs_sent, timers_added, adds_refused, timers_freed);
    $display("run: %0d timers fired, %0d wait answers, %0d results checked, %0d faults",
             timers_fired, wait_answers, results_seen, fault_count);
    if (fault_count == 0 && owed_answers.size() == 0) begin
      $display("timeout_slot_table_core_tb: clean");
    end else begin
      $display("timeout_slot_table_core_tb: errors");
    end
    $finish;
  end

endmodule
